// ----- src/assert_macros.svh -----
// ============================================================================
// assert_macros.svh
// Assertion macros used by the verification checker of this block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of aclk.
`define TPST_ASSERT_IMP(lbl, dis, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge of aclk.
`define TPST_ASSERT_NXT(lbl, dis, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/tpst_pkg.sv -----
// ============================================================================
// tpst_pkg
// Widths, constants, codes and shared types of the spin timeout tracker.
// ============================================================================
package tpst_pkg;

    localparam int BUDGET_W   = 32;
    localparam int TB_W       = 64;
    localparam int TICK_W     = 32;
    localparam int HZ_W       = 32;
    localparam int TICK_HZ_W  = 17;
    localparam int SCALE_W    = 20;
    localparam int PROD_W     = TB_W + SCALE_W;
    localparam int QUO_W      = 32;
    localparam int UPPER_W    = PROD_W - QUO_W;
    localparam int SCALED_W   = QUO_W + SCALE_W;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = BUDGET_W + TB_W + TICK_W;
    localparam int M_TDATA_W  = 8;
    localparam int MUL_CNT_W  = $clog2(SCALE_W + 1);
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    localparam logic [SCALE_W-1:0]   USECS_PER_SEC       = 20'd1000000;
    localparam logic [SCALE_W-1:0]   MSECS_PER_SEC       = 20'd1000;
    localparam logic [HZ_W-1:0]      TIMEBASE_HZ_RESET   = 32'd10000000;
    localparam logic [TICK_HZ_W-1:0] CLOCK_TICK_HZ_RESET = 17'd60;
    localparam logic [QUO_W-1:0]     SWITCH_USECS        = 32'd1000;

    localparam logic [PHASE_W-1:0] PH_CHECK  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LATCH  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FINE   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_COARSE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEBASE_HZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_TICK_HZ = 2'd1;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_res_t;

    typedef struct packed {
        logic             done;
        logic             big;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

// ----- src/tpst_mul.sv -----
// ============================================================================
// tpst_mul
// Serial constant multiplier: one bit of the scale factor per cycle.
// ============================================================================
module tpst_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpst_pkg::TB_W-1:0]     x,
    input  logic [tpst_pkg::SCALE_W-1:0]  k,
    output tpst_pkg::mul_res_t            res
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [tpst_pkg::MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [tpst_pkg::SCALE_W-1:0]     k_reg, k_next;
    logic [tpst_pkg::TB_W-1:0]        x_reg, x_next;
    logic [tpst_pkg::PROD_W-1:0]      acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = tpst_pkg::MUL_CNT_W'(tpst_pkg::SCALE_W);
            k_next    = k;
            x_next    = x;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = {acc_reg[tpst_pkg::PROD_W-2:0], 1'b0}
                     + (k_reg[tpst_pkg::SCALE_W-1] ? tpst_pkg::PROD_W'(x_reg)
                                                  : tpst_pkg::PROD_W'(0));
            k_next   = {k_reg[tpst_pkg::SCALE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tpst_pkg::MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign res.done = done_reg;
    assign res.prod = acc_reg;

endmodule

// ----- src/tpst_div.sv -----
// ============================================================================
// tpst_div
// Bit-serial restoring divider with a saturation flag for quotients >= 2^32.
// ============================================================================
module tpst_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpst_pkg::PROD_W-1:0]   dividend,
    input  logic [tpst_pkg::HZ_W-1:0]     divisor,
    output tpst_pkg::div_res_t            res
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic                             big_reg, big_next;
    logic [tpst_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [tpst_pkg::HZ_W-1:0]        rem_reg, rem_next;
    logic [tpst_pkg::HZ_W-1:0]        d_reg, d_next;
    logic [tpst_pkg::QUO_W-1:0]       quo_reg, quo_next;

    logic [tpst_pkg::UPPER_W-1:0]     upper;
    logic [tpst_pkg::HZ_W:0]          trial;
    logic [tpst_pkg::HZ_W:0]          diff;
    logic                             ge;

    assign upper = dividend[tpst_pkg::PROD_W-1:tpst_pkg::QUO_W];
    assign trial = {rem_reg, quo_reg[tpst_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        big_next  = big_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        quo_next  = quo_reg;
        if (start) begin
            if (upper >= tpst_pkg::UPPER_W'(divisor)) begin
                big_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                big_next  = 1'b0;
                busy_next = 1'b1;
                rem_next  = upper[tpst_pkg::HZ_W-1:0];
                quo_next  = dividend[tpst_pkg::QUO_W-1:0];
                d_next    = divisor;
                cnt_next  = tpst_pkg::DIV_CNT_W'(tpst_pkg::QUO_W - 1);
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[tpst_pkg::HZ_W-1:0] : trial[tpst_pkg::HZ_W-1:0];
            quo_next = {quo_reg[tpst_pkg::QUO_W-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        big_reg <= big_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        quo_reg <= quo_next;
    end

    assign res.done = done_reg;
    assign res.big  = big_reg;
    assign res.quo  = quo_reg;

endmodule

// ----- src/two_phase_spin_timeout.sv -----
// ============================================================================
// two_phase_spin_timeout
// Busy-wait timeout tracker with a fine and a coarse measurement phase.
// ============================================================================
// The s_ channel takes one item per transfer: s_tuser is the function (start
// or check), s_tdata carries the budget, the fine timebase count and the
// coarse tick count. Every item yields exactly one result transfer on the m_
// channel. The cfg channel writes the two frequency registers and is always
// ready; it must be written only while the block is idle, which it does not enforce.
// Start items and checks in the first two phases go straight to the finish
// state after the input transfer. A measuring check runs a serial multiply
// by the scale factor and then a bit-serial division by the configured
// frequency; the coarse phase adds a rescale step. One item is in work at a
// time, and the next transfer is taken as soon as the result sits in the
// output register.
// A stalled receiver holds the result in that register; the block keeps
// working on the next item and waits only when a second result is ready.
// Reset returns the tracker to its first phase with a zero budget and the
// frequency registers at their defaults, with no result pending.
module two_phase_spin_timeout #(
    parameter logic [tpst_pkg::QUO_W-1:0] SWITCH_USECS = tpst_pkg::SWITCH_USECS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // budget_usecs [31:0], timebase_now [95:32], ticks_now [127:96]
    input  logic [tpst_pkg::S_TDATA_W-1:0]    s_tdata,
    // func [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // keep_spinning [0], timed_out [1], zero [7:2]
    output logic [tpst_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpst_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_SCALE  = 6'b001000,
        ST_EVAL   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t                                state_reg, state_next;
    logic [tpst_pkg::PHASE_W-1:0]          phase_reg, phase_next;
    logic [tpst_pkg::BUDGET_W-1:0]         rem_reg, rem_next;
    logic [tpst_pkg::TB_W-1:0]             base_tb_reg, base_tb_next;
    logic [tpst_pkg::TICK_W-1:0]           base_tk_reg, base_tk_next;
    logic                                  expired_reg, expired_next;
    logic [tpst_pkg::HZ_W-1:0]             tb_hz_reg, tb_hz_next;
    logic [tpst_pkg::TICK_HZ_W-1:0]        tk_hz_reg, tk_hz_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [1:0]                            m_data_reg, m_data_next;
    logic [tpst_pkg::TICK_W-1:0]           item_tk_reg, item_tk_next;
    logic                                  coarse_reg, coarse_next;
    logic                                  keep_reg, keep_next;
    logic                                  big_reg, big_next;
    logic [tpst_pkg::QUO_W-1:0]            quo_reg, quo_next;
    logic [tpst_pkg::SCALED_W-1:0]         scaled_reg, scaled_next;

    logic                                  s_accept;
    logic                                  out_free;
    logic                                  func;
    logic [tpst_pkg::BUDGET_W-1:0]         budget;
    logic [tpst_pkg::TB_W-1:0]             tb_now;
    logic [tpst_pkg::TICK_W-1:0]           tk_now;
    logic [tpst_pkg::TICK_W-1:0]           tk_diff;
    logic                                  mul_start;
    logic [tpst_pkg::TB_W-1:0]             mul_x;
    logic [tpst_pkg::SCALE_W-1:0]          mul_k;
    logic                                  div_start;
    logic [tpst_pkg::HZ_W-1:0]             div_sel;
    logic [tpst_pkg::HZ_W-1:0]             div_d;
    logic                                  timeout;
    tpst_pkg::mul_res_t                    mul_res;
    tpst_pkg::div_res_t                    div_res;

    assign func     = s_tuser;
    assign budget   = s_tdata[tpst_pkg::BUDGET_W-1:0];
    assign tb_now   = s_tdata[tpst_pkg::BUDGET_W +: tpst_pkg::TB_W];
    assign tk_now   = s_tdata[tpst_pkg::BUDGET_W + tpst_pkg::TB_W +: tpst_pkg::TICK_W];
    assign tk_diff  = tk_now - base_tk_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = tpst_pkg::M_TDATA_W'(m_data_reg);

    assign div_sel = coarse_reg ? tpst_pkg::HZ_W'(tk_hz_reg) : tb_hz_reg;
    assign div_d   = (div_sel == '0) ? tpst_pkg::HZ_W'(1) : div_sel;

    assign timeout = coarse_reg
                   ? (big_reg || scaled_reg >= tpst_pkg::SCALED_W'(rem_reg))
                   : (big_reg || quo_reg >= rem_reg);

    tpst_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .k       (mul_k),
        .res     (mul_res)
    );

    tpst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_res.prod),
        .divisor  (div_d),
        .res      (div_res)
    );

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        base_tb_next = base_tb_reg;
        base_tk_next = base_tk_reg;
        expired_next = expired_reg;
        tb_hz_next   = tb_hz_reg;
        tk_hz_next   = tk_hz_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        item_tk_next = item_tk_reg;
        coarse_next  = coarse_reg;
        keep_next    = keep_reg;
        big_next     = big_reg;
        quo_next     = quo_reg;
        scaled_next  = scaled_reg;
        mul_start    = 1'b0;
        mul_x        = '0;
        mul_k        = '0;
        div_start    = 1'b0;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tpst_pkg::REG_TIMEBASE_HZ: begin
                    tb_hz_next = cfg_data;
                end
                tpst_pkg::REG_CLOCK_TICK_HZ: begin
                    tk_hz_next = cfg_data[tpst_pkg::TICK_HZ_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    keep_next  = 1'b1;
                    state_next = ST_FINISH;
                    if (func) begin
                        phase_next   = tpst_pkg::PH_CHECK;
                        rem_next     = budget;
                        expired_next = 1'b0;
                    end else begin
                        case (phase_reg)
                            tpst_pkg::PH_CHECK: begin
                                phase_next = tpst_pkg::PH_LATCH;
                            end
                            tpst_pkg::PH_LATCH: begin
                                base_tb_next = tb_now;
                                phase_next   = tpst_pkg::PH_FINE;
                            end
                            tpst_pkg::PH_FINE: begin
                                mul_start    = 1'b1;
                                mul_x        = tb_now - base_tb_reg;
                                mul_k        = tpst_pkg::USECS_PER_SEC;
                                coarse_next  = 1'b0;
                                item_tk_next = tk_now;
                                state_next   = ST_MUL;
                            end
                            default: begin
                                mul_start   = 1'b1;
                                mul_x       = tpst_pkg::TB_W'(tk_diff);
                                mul_k       = tpst_pkg::MSECS_PER_SEC;
                                coarse_next = 1'b1;
                                state_next  = ST_MUL;
                            end
                        endcase
                    end
                end
            end
            ST_MUL: begin
                if (mul_res.done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    quo_next   = div_res.quo;
                    big_next   = div_res.big;
                    state_next = coarse_reg ? ST_SCALE : ST_EVAL;
                end
            end
            ST_SCALE: begin
                scaled_next = tpst_pkg::SCALED_W'(quo_reg)
                            * tpst_pkg::SCALED_W'(tpst_pkg::MSECS_PER_SEC);
                state_next  = ST_EVAL;
            end
            ST_EVAL: begin
                if (timeout) begin
                    expired_next = 1'b1;
                    keep_next    = 1'b0;
                end else if (!coarse_reg && quo_reg >= SWITCH_USECS) begin
                    rem_next     = rem_reg - quo_reg;
                    base_tk_next = item_tk_reg;
                    phase_next   = tpst_pkg::PH_COARSE;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {expired_reg, keep_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= tpst_pkg::PH_CHECK;
            rem_reg     <= '0;
            base_tb_reg <= '0;
            base_tk_reg <= '0;
            expired_reg <= 1'b0;
            tb_hz_reg   <= tpst_pkg::TIMEBASE_HZ_RESET;
            tk_hz_reg   <= tpst_pkg::CLOCK_TICK_HZ_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            base_tb_reg <= base_tb_next;
            base_tk_reg <= base_tk_next;
            expired_reg <= expired_next;
            tb_hz_reg   <= tb_hz_next;
            tk_hz_reg   <= tk_hz_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        item_tk_reg <= item_tk_next;
        coarse_reg  <= coarse_next;
        keep_reg    <= keep_next;
        big_reg     <= big_next;
        quo_reg     <= quo_next;
        scaled_reg  <= scaled_next;
    end

endmodule

// ----- src/tpst_checker.sv -----
// ============================================================================
// tpst_checker
// Port-level checks of the spin timeout tracker, bound to its top level.
// ============================================================================
`include "assert_macros.svh"

module tpst_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tpst_pkg::M_TDATA_W-1:0]    m_tdata
);

    // A stalled result stays put until its transfer completes.
    `TPST_ASSERT_NXT(a_out_hold, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A timeout report always comes with the sticky flag, and padding is zero.
    `TPST_ASSERT_IMP(a_out_flags, !aresetn, m_tvalid, (m_tdata[0] || m_tdata[1]) && m_tdata[7:2] == 6'd0)

    // Only one item is in work at a time.
    `TPST_ASSERT_NXT(a_one_item, !aresetn, s_tvalid && s_tready, !s_tready)

    // Reset leaves the block ready with no result pending.
    `TPST_ASSERT_NXT(a_reset, 1'b0, !aresetn, s_tready && !m_tvalid)

endmodule

bind two_phase_spin_timeout tpst_checker u_tpst_checker (.*);

// ----- test/two_phase_spin_timeout_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// two_phase_spin_timeout_tb
// Self-checking bench for the busy-wait timeout tracker.
// ============================================================================
// A queue of wait sequences (a start followed by timebase and tick samples
// that advance at the configured rates) plus random noise items feeds a
// bursty stream driver. A behavioral copy of the four-phase tracker predicts
// each result as its input transfer is accepted. The monitor checks every
// result transfer in order against those predictions while the receiver
// stalls in changing patterns. The frequency registers are swept through
// typical, extreme and zero settings between drained phases.
module two_phase_spin_timeout_tb;

    localparam logic FUNC_CHECK      = 1'b0;
    localparam logic FUNC_START      = 1'b1;
    localparam int   IDLE_LIMIT      = 5000;
    localparam int   DRAIN_CYCLES    = 100;
    localparam int   ITEMS_PER_PHASE = 225;
    localparam int   NUM_SETTINGS    = 7;
    localparam int   LONG_HOLD_AT    = 400;
    localparam int   LONG_HOLD_LEN   = 600;
    localparam int   MAX_REPORTS     = 10;

    typedef struct {
        logic                          func;
        logic [tpst_pkg::BUDGET_W-1:0] budget;
        logic [tpst_pkg::TB_W-1:0]     tb_now;
        logic [tpst_pkg::TICK_W-1:0]   ticks_now;
    } wait_item_t;

    typedef struct {
        logic keep_spinning;
        logic timed_out;
    } spin_result_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [tpst_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [tpst_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tpst_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tpst_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    wait_item_t   wait_items[$];
    spin_result_t spin_expected[$];
    wait_item_t   in_flight;

    logic [tpst_pkg::HZ_W-1:0]      tb_hz_q;
    logic [tpst_pkg::TICK_HZ_W-1:0] tick_hz_q;
    logic [tpst_pkg::PHASE_W-1:0]   trk_phase;
    logic [tpst_pkg::BUDGET_W-1:0]  trk_remaining;
    logic [tpst_pkg::TB_W-1:0]      trk_base_tb;
    logic [tpst_pkg::TICK_W-1:0]    trk_base_ticks;
    logic                           trk_expired;

    int       items_accepted = 0;
    int       fail_count     = 0;
    int       burst_left     = 0;
    int       gap_left       = 0;
    int       idle_cycles    = 0;
    int       mode_left      = 0;
    int       hold_left      = 0;
    logic     long_hold_done = 1'b0;
    rx_mode_e rx_mode        = RX_OPEN;

    two_phase_spin_timeout u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] fine_usecs(input logic [tpst_pkg::TB_W-1:0] diff,
                                               input logic [tpst_pkg::HZ_W-1:0] hz);
        logic [63:0] h;
        logic [63:0] whole;
        logic [63:0] part;
        h = (hz == '0) ? 64'd1 : {32'd0, hz};
        whole = diff / h;
        part = diff % h;
        if (whole >= 64'd4295) begin
            return 64'h1_0000_0000;
        end
        return whole * 64'd1000000 + (part * 64'd1000000) / h;
    endfunction

    function automatic logic [63:0] coarse_usecs(input logic [tpst_pkg::TICK_W-1:0] diff,
                                                 input logic [tpst_pkg::TICK_HZ_W-1:0] hz);
        logic [63:0] h;
        h = (hz == '0) ? 64'd1 : {47'd0, hz};
        return (({32'd0, diff} * 64'd1000) / h) * 64'd1000;
    endfunction

    function automatic spin_result_t predict_spin(input wait_item_t it);
        spin_result_t res;
        logic [63:0]  elapsed;
        res.keep_spinning = 1'b1;
        if (it.func == FUNC_START) begin
            trk_phase = tpst_pkg::PH_CHECK;
            trk_remaining = it.budget;
            trk_expired = 1'b0;
        end else begin
            case (trk_phase)
                tpst_pkg::PH_CHECK: trk_phase = tpst_pkg::PH_LATCH;
                tpst_pkg::PH_LATCH: begin
                    trk_base_tb = it.tb_now;
                    trk_phase = tpst_pkg::PH_FINE;
                end
                tpst_pkg::PH_FINE: begin
                    elapsed = fine_usecs(it.tb_now - trk_base_tb, tb_hz_q);
                    if (elapsed >= {32'd0, trk_remaining}) begin
                        trk_expired = 1'b1;
                        res.keep_spinning = 1'b0;
                    end else if (elapsed >= {32'd0, tpst_pkg::SWITCH_USECS}) begin
                        trk_remaining = trk_remaining - elapsed[31:0];
                        trk_base_ticks = it.ticks_now;
                        trk_phase = tpst_pkg::PH_COARSE;
                    end
                end
                default: begin
                    elapsed = coarse_usecs(it.ticks_now - trk_base_ticks, tick_hz_q);
                    if (elapsed >= {32'd0, trk_remaining}) begin
                        trk_expired = 1'b1;
                        res.keep_spinning = 1'b0;
                    end
                end
            endcase
        end
        res.timed_out = trk_expired;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("%s", msg);
        end
        fail_count++;
    endtask

    task automatic push_item(input logic func, input logic [tpst_pkg::BUDGET_W-1:0] budget,
                             input logic [tpst_pkg::TB_W-1:0] tb_now,
                             input logic [tpst_pkg::TICK_W-1:0] ticks_now);
        wait_item_t it;
        it.func = func;
        it.budget = budget;
        it.tb_now = tb_now;
        it.ticks_now = ticks_now;
        wait_items.push_back(it);
    endtask

    // One wait: a start, then samples whose counters advance at the set rates.
    task automatic queue_sequence(input logic [tpst_pkg::HZ_W-1:0] hz,
                                  input logic [tpst_pkg::TICK_HZ_W-1:0] tick_hz,
                                  inout int added);
        logic [tpst_pkg::BUDGET_W-1:0] budget;
        logic [tpst_pkg::TB_W-1:0]     tb;
        logic [tpst_pkg::TICK_W-1:0]   tk;
        logic [63:0]                   h;
        logic [63:0]                   th;
        logic [63:0]                   us;
        int                            step_us;
        int                            n;
        h = (hz == '0) ? 64'd1 : {32'd0, hz};
        th = (tick_hz == '0) ? 64'd1 : {47'd0, tick_hz};
        case ($urandom_range(0, 5))
            0: budget = $urandom_range(0, 2000);
            1: budget = $urandom_range(1000, 20000);
            2: budget = $urandom_range(0, 2000000);
            3: budget = $urandom;
            4: budget = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: budget = $urandom_range(990, 1100);
        endcase
        case ($urandom_range(0, 3))
            0: step_us = 50;
            1: step_us = 500;
            2: step_us = 5000;
            default: step_us = 100000;
        endcase
        tb = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            tb = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 100000);
        end
        tk = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            tk = 32'hFFFF_FFFF - $urandom_range(0, 50);
        end
        if ($urandom_range(0, 7) != 0) begin
            push_item(FUNC_START, budget, {$urandom, $urandom}, $urandom);
            added++;
        end
        n = $urandom_range(3, 24);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                tb = {$urandom, $urandom};
                tk = $urandom;
            end else begin
                us = $urandom_range(0, step_us);
                tb = tb + (h * us) / 64'd1000000 + $urandom_range(0, 1);
                tk = tk + 32'((th * us) / 64'd1000000) + ($urandom_range(0, 3) == 0);
            end
            push_item(FUNC_CHECK, $urandom, tb, tk);
            added++;
        end
    endtask

    task automatic queue_random(input logic [tpst_pkg::HZ_W-1:0] hz,
                                input logic [tpst_pkg::TICK_HZ_W-1:0] tick_hz,
                                input int count);
        int added;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item($urandom_range(0, 1) ? FUNC_START : FUNC_CHECK, $urandom,
                          {$urandom, $urandom}, $urandom);
                added++;
            end else begin
                queue_sequence(hz, tick_hz, added);
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (wait_items.size() != 0 || s_tvalid || spin_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tpst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpst_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tb_hz_q = tpst_pkg::TIMEBASE_HZ_RESET;
            tick_hz_q = tpst_pkg::CLOCK_TICK_HZ_RESET;
            trk_phase = tpst_pkg::PH_CHECK;
            trk_remaining = '0;
            trk_base_tb = '0;
            trk_base_ticks = '0;
            trk_expired = 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tpst_pkg::REG_TIMEBASE_HZ) begin
                    tb_hz_q = cfg_data[tpst_pkg::HZ_W-1:0];
                end else if (cfg_index == tpst_pkg::REG_CLOCK_TICK_HZ) begin
                    tick_hz_q = cfg_data[tpst_pkg::TICK_HZ_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                spin_expected.push_back(predict_spin(in_flight));
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (wait_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    in_flight = wait_items.pop_front();
                    s_tdata <= {in_flight.ticks_now, in_flight.tb_now, in_flight.budget};
                    s_tuser <= in_flight.func;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // The long hold lets the output register fill while the sender keeps offering.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && items_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge aclk) begin
        spin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (spin_expected.size() == 0) begin
                note_failure($sformatf("%0t: result transfer with none expected, tdata=%h",
                                       $time, m_tdata));
            end else begin
                want = spin_expected.pop_front();
                if (m_tdata[0] !== want.keep_spinning) begin
                    note_failure($sformatf("%0t: keep_spinning expected %0b, got %0b",
                                           $time, want.keep_spinning, m_tdata[0]));
                end
                if (m_tdata[1] !== want.timed_out) begin
                    note_failure($sformatf("%0t: timed_out expected %0b, got %0b",
                                           $time, want.timed_out, m_tdata[1]));
                end
                if (m_tdata[tpst_pkg::M_TDATA_W-1:2] !== '0) begin
                    note_failure($sformatf("%0t: padding expected 0, got %h",
                                           $time, m_tdata[tpst_pkg::M_TDATA_W-1:2]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [tpst_pkg::HZ_W-1:0]      tb_hz_set[NUM_SETTINGS];
        logic [tpst_pkg::TICK_HZ_W-1:0] tick_hz_set[NUM_SETTINGS];
        tb_hz_set = '{tpst_pkg::TIMEBASE_HZ_RESET, 32'd1, 32'hFFFF_FFFF, 32'd0,
                      32'd1000000, 32'd0, 32'd10000000};
        tick_hz_set = '{tpst_pkg::CLOCK_TICK_HZ_RESET, 17'd1, 17'd100000, 17'd0,
                        17'd1000, 17'd1, 17'd60};
        tb_hz_set[5] = $urandom;
        tick_hz_set[5] = $urandom_range(1, 100000);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // After reset: zero budget, then a timeout that repeats on later checks.
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        // Full budget, timebase wrap, switch to coarse, tick wrap, wide coarse time.
        push_item(FUNC_START, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'hFFFF_FFFF_FFFF_FF00, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'h0000_0000_0000_1000, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'h0000_0000_0000_4D20, 32'hFFFF_FFF0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'h0000_0010);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'hFFFF_FFEF);
        // A huge timebase jump saturates the fine elapsed time.
        push_item(FUNC_START, 32'd5000, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        // Switch at exactly the fine spin limit, then a coarse timeout.
        push_item(FUNC_START, 32'd1500, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd100, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd10100, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd10100, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd10100, 32'd1);
        push_item(FUNC_CHECK, 32'd0, 64'd10100, 32'd1);
        // Zero budget after a start times out on the first measurement.
        push_item(FUNC_START, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd0, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd5, 32'd0);
        push_item(FUNC_CHECK, 32'd0, 64'd5, 32'd0);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                wait_drained();
                write_reg(tpst_pkg::REG_TIMEBASE_HZ, tb_hz_set[s]);
                write_reg(tpst_pkg::REG_CLOCK_TICK_HZ, {15'd0, tick_hz_set[s]});
            end
            if (s == 4) begin
                queue_random(tb_hz_set[s], tick_hz_set[s], ITEMS_PER_PHASE / 2);
                wait_drained();
                queue_random(tb_hz_set[s], tick_hz_set[s], ITEMS_PER_PHASE / 2);
            end else begin
                queue_random(tb_hz_set[s], tick_hz_set[s], ITEMS_PER_PHASE);
            end
        end

        wait_drained();
        if (fail_count == 0 && spin_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
